// ===== rtl/smef_pkg.sv =====
// ============================================================================
// smef_pkg: shared constants for the sphere minus ellipsoid field evaluator
// register indexes of the configuration port and fixed internal widths
// ============================================================================
`default_nettype none

package smef_pkg;

  // internal gradient magnitude: capped at 2^62, so 63 bits hold it
  localparam int G_Q_W = 63;
  localparam logic [G_Q_W-1:0] G_CAP = {1'b1, {(G_Q_W-1){1'b0}}};

  // split point of the gradient products into partial products
  localparam int G_LO_W = 32;
  localparam int G_HI_W = G_Q_W - G_LO_W;

  // common magnitude width seen by the saturation logic
  localparam int SAT_W = 128;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INSIDE_MODE      = 3'd0,
    REG_CENTER_X         = 3'd1,
    REG_CENTER_Y         = 3'd2,
    REG_CENTER_Z         = 3'd3,
    REG_SPHERE_RADIUS    = 3'd4,
    REG_ELLIPSOID_SHIFT  = 3'd5,
    REG_ELLIPSOID_RADIUS = 3'd6,
    REG_ECCENTRICITY     = 3'd7
  } smef_reg_e;

endpackage

`default_nettype wire

// ===== rtl/smef_sqrt.sv =====
// ============================================================================
// smef_sqrt: pipelined integer square root
// one root bit per stage, several lanes in lockstep, a tag rides along
// ============================================================================
`default_nettype none

module smef_sqrt #(
  parameter int IN_W  = 84,
  parameter int LANES = 2,
  parameter int TAG_W = 8,
  localparam int R_W  = (IN_W + 1) / 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [LANES-1:0][IN_W-1:0]     rad_i,
  input  wire logic [TAG_W-1:0]               tag_i,
  output logic                                valid_o,
  output logic      [LANES-1:0][R_W-1:0]      root_o,
  output logic      [TAG_W-1:0]               tag_o
);

  localparam int P_W  = 2 * R_W;
  localparam int RM_W = R_W + 2;
  localparam int CW   = RM_W + 2;

  logic [R_W:0]                  vld_q;
  logic [LANES-1:0][P_W-1:0]     rad_q  [R_W+1];
  logic [LANES-1:0][RM_W-1:0]    rem_q  [R_W+1];
  logic [LANES-1:0][R_W-1:0]     root_q [R_W+1];
  logic [TAG_W-1:0]              tag_q  [R_W+1];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rad_q[0][l]  <= P_W'(rad_i[l]);
        rem_q[0][l]  <= '0;
        root_q[0][l] <= '0;
      end
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [LANES-1:0][RM_W-1:0] rem_d;
    logic [LANES-1:0][R_W-1:0]  root_d;

    // bring down two radicand bits, try root*4+1
    always_comb begin
      logic [CW-1:0] cur;
      logic [CW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        cur   = {rem_q[k][l], rad_q[k][l][P_W-1 -: 2]};
        trial = CW'({root_q[k][l], 2'b01});
        if (cur >= trial) begin
          rem_d[l]  = RM_W'(cur - trial);
          root_d[l] = {root_q[k][l][R_W-2:0], 1'b1};
        end else begin
          rem_d[l]  = RM_W'(cur);
          root_d[l] = {root_q[k][l][R_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          rad_q[k+1][l] <= rad_q[k][l] << 2;
        end
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        tag_q[k+1]  <= tag_q[k];
      end
    end
  end

  assign valid_o = vld_q[R_W];
  assign root_o  = root_q[R_W];
  assign tag_o   = tag_q[R_W];

endmodule

`default_nettype wire

// ===== rtl/smef_div.sv =====
// ============================================================================
// smef_div: pipelined restoring divider
// one quotient bit per stage, lanes share the divisor, overflow flagged
// ============================================================================
`default_nettype none

module smef_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 42,
  parameter int Q_W   = 63,
  parameter int LANES = 3,
  parameter int TAG_W = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]             den_i,
  input  wire logic [TAG_W-1:0]             tag_i,
  output logic                              valid_o,
  output logic      [LANES-1:0][Q_W-1:0]    quot_o,
  output logic      [LANES-1:0]             ovf_o,
  output logic      [TAG_W-1:0]             tag_o
);

  localparam int PN_W  = (NUM_W > Q_W) ? NUM_W : Q_W + 1;
  localparam int HI_W  = PN_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int RC_W  = DEN_W + 1;

  logic [Q_W:0]                  vld_q;
  logic [LANES-1:0][DEN_W-1:0]   rem_q [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]     lq_q  [Q_W+1];
  logic [LANES-1:0]              ovf_q [Q_W+1];
  logic [DEN_W-1:0]              den_q [Q_W+1];
  logic [TAG_W-1:0]              tag_q [Q_W+1];

  logic [LANES-1:0][DEN_W-1:0]   rem0_d;
  logic [LANES-1:0][Q_W-1:0]     lq0_d;
  logic [LANES-1:0]              ovf0_d;

  // quotient fits in Q_W bits only when the high part is below the divisor
  always_comb begin
    logic [PN_W-1:0] pn;
    logic [HI_W-1:0] hi;
    for (int l = 0; l < LANES; l++) begin
      pn        = PN_W'(num_i[l]);
      hi        = pn[PN_W-1:Q_W];
      ovf0_d[l] = CMP_W'(hi) >= CMP_W'(den_i);
      rem0_d[l] = DEN_W'(hi);
      lq0_d[l]  = pn[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_d;
      lq_q[0]  <= lq0_d;
      ovf_q[0] <= ovf0_d;
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_d;
    logic [LANES-1:0][Q_W-1:0]   lq_d;

    // numerator bits leave the top of lq, quotient bits enter at the bottom
    always_comb begin
      logic [RC_W-1:0] cur;
      logic            qb;
      for (int l = 0; l < LANES; l++) begin
        cur = {rem_q[k][l], lq_q[k][l][Q_W-1]};
        qb  = cur >= {1'b0, den_q[k]};
        if (qb) begin
          rem_d[l] = DEN_W'(cur - {1'b0, den_q[k]});
        end else begin
          rem_d[l] = DEN_W'(cur);
        end
        lq_d[l] = {lq_q[k][l][Q_W-2:0], qb};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        lq_q[k+1]  <= lq_d;
        ovf_q[k+1] <= ovf_q[k];
        den_q[k+1] <= den_q[k];
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quot_o  = lq_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

`default_nettype wire

// ===== rtl/sphere_minus_ellipsoid_field.sv =====
// ============================================================================
// sphere_minus_ellipsoid_field: implicit field of a sphere with an ellipsoid
// cut away, with gradient and hessian of the winning term, fixed point
// ============================================================================
// usage
//   s_axis carries one query point per beat: point_x, point_y, point_z.
//   m_axis returns one beat per point: field value, gradient and the six
//   distinct hessian terms in tdata, ellipsoid_branch and degenerate in tuser.
//   the cfg port writes one register per cycle; write only while no beat is
//   in flight, the new value applies to every later point.
// throughput
//   one point per cycle, sustained while the output is not held. the root
//   width of the square root pipeline is 42 at the defaults. the two
//   dividers, one quotient bit per stage, make up most of the pipeline.
// reset
//   all valid bits clear, registers go to: inside_mode 0, centers 0, radii,
//   shift and eccentricity 65536.
// stall
//   the whole pipeline holds while the output beat waits; s_axis_tready
//   drops in the same cycle, no beat is lost or repeated.
// ============================================================================
`default_nettype none

module sphere_minus_ellipsoid_field #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // point_x, point_y, point_z
  input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // field_value, grad_x, grad_y, grad_z, hess_xx, hess_yy, hess_zz,
  // hess_xy, hess_xz, hess_yz
  output logic      [((10*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // ellipsoid_branch, degenerate
  output logic      [1:0]                             m_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  input  wire logic                                   cfg_we_i,
  input  wire logic [smef_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0]                  cfg_data_i
);

  import smef_pkg::*;

  localparam int W        = DATA_WIDTH;
  localparam int F        = FRAC_BITS;
  localparam int OUT_TD_W = ((10*W+7)/8)*8;
  localparam int A_W      = W + 1;                 // |point - center|
  localparam int EY_W     = A_W + 1;               // signed ellipsoid y offset
  localparam int E_W      = W - 1;                 // unsigned registers
  localparam int SQ_W     = 2 * A_W;
  localparam int HLF      = A_W;                   // split of a square
  localparam int PP_W     = E_W + HLF;
  localparam int EF_W     = E_W + SQ_W;
  localparam int ET_W     = EF_W - F;
  localparam int S2_W     = SQ_W + 2;
  localparam int E2_W     = ((ET_W > SQ_W) ? ET_W : SQ_W) + 2;
  localparam int SQI_W    = (S2_W > E2_W) ? S2_W : E2_W;
  localparam int LEN_W    = (SQI_W + 1) / 2;
  localparam int V_W      = LEN_W + 2;
  localparam int EA_W     = E_W + A_W;
  localparam int GN_W     = ((A_W + F) > EA_W) ? (A_W + F) : EA_W;
  localparam int GG_W     = 2 * G_Q_W;
  localparam int WT_W     = ((F + 1) > E_W) ? (F + 1) : E_W;
  localparam logic [W-1:0] ONE_RST = W'(65536);

  // product pairs in output order xx, yy, zz, xy, xz, yz
  localparam int PI [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [2:0][A_W-1:0]  a;
    logic [A_W-1:0]       aey;
    logic [1:0][EA_W-1:0] ea;       // e*|dx|, e*|dz|
    logic [2:0]           neg;
    logic                 pos_x;
    logic                 pos_z;
    logic                 eypos;
  } pre_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         br;
    logic         degen;
    logic [2:0]   gneg;
  } mid_t;

  typedef struct packed {
    logic [W-1:0]       value;
    logic [2:0][W-1:0]  grad;
    logic               br;
    logic               degen;
    logic [2:0]         gneg;
  } grd_t;

  typedef struct packed {
    logic [W-1:0]       value;
    logic [2:0][W-1:0]  grad;
    logic               br;
    logic               degen;
    logic [5:0]         hsgn;
  } res_t;

  function automatic logic [W-1:0] sat_fn(input logic neg, input logic [SAT_W-1:0] mag);
    logic [SAT_W-1:0] lim;
    logic [W-1:0]     v;
    lim = neg ? (SAT_W'(1) << (W - 1)) : ((SAT_W'(1) << (W - 1)) - SAT_W'(1));
    v   = (mag > lim) ? lim[W-1:0] : mag[W-1:0];
    return neg ? (~v + W'(1)) : v;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                inside_q;
  logic signed [W-1:0] ctr_q [3];
  logic [E_W-1:0]      rs_q;
  logic signed [W-1:0] sh_q;
  logic [E_W-1:0]      re_q;
  logic [E_W-1:0]      ecc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      rs_q     <= ONE_RST[E_W-1:0];
      sh_q     <= ONE_RST;
      re_q     <= ONE_RST[E_W-1:0];
      ecc_q    <= ONE_RST[E_W-1:0];
    end else if (cfg_we_i) begin
      unique case (smef_reg_e'(cfg_idx_i))
        REG_INSIDE_MODE:      inside_q <= cfg_data_i[0];
        REG_CENTER_X:         ctr_q[0] <= cfg_data_i;
        REG_CENTER_Y:         ctr_q[1] <= cfg_data_i;
        REG_CENTER_Z:         ctr_q[2] <= cfg_data_i;
        REG_SPHERE_RADIUS:    rs_q     <= cfg_data_i[E_W-1:0];
        REG_ELLIPSOID_SHIFT:  sh_q     <= cfg_data_i;
        REG_ELLIPSOID_RADIUS: re_q     <= cfg_data_i[E_W-1:0];
        REG_ECCENTRICITY:     ecc_q    <= cfg_data_i[E_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: every stage moves when the output register can take a beat
  // --------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v8_q, v9_q, v10_q, v11_q;
  logic sqrt_vld, divg_vld, divh_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      v11_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= sqrt_vld;
      v8_q      <= divg_vld;
      v9_q      <= v8_q;
      v10_q     <= v9_q;
      v11_q     <= v10_q;
      out_vld_q <= divh_vld;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: offsets from the sphere center and the ellipsoid center
  // --------------------------------------------------------------------------
  logic signed [W-1:0]    pt [3];
  logic signed [A_W-1:0]  d_d [3];
  logic signed [EY_W-1:0] ey_d;
  logic signed [A_W-1:0]  d_q [3];
  logic signed [EY_W-1:0] ey_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]  = s_axis_tdata[i*W +: W];
      d_d[i] = A_W'(pt[i]) - A_W'(ctr_q[i]);
    end
    ey_d = EY_W'(d_d[1]) - EY_W'(sh_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q  <= d_d;
      ey_q <= ey_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitudes and signs
  // --------------------------------------------------------------------------
  logic [A_W-1:0] a2_q [3];
  logic [A_W-1:0] aey2_q;
  logic [2:0]     neg2_q;
  logic [2:0]     pos2_q;
  logic           eypos2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a2_q[i]   <= d_q[i][A_W-1] ? A_W'(-d_q[i]) : A_W'(d_q[i]);
        neg2_q[i] <= d_q[i][A_W-1];
        pos2_q[i] <= !d_q[i][A_W-1] && (d_q[i] != '0);
      end
      aey2_q   <= ey_q[EY_W-1] ? A_W'(-ey_q) : A_W'(ey_q);
      eypos2_q <= !ey_q[EY_W-1] && (ey_q != '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: squares and the weighted x, z terms of the gradient numerator
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0] sq3_q [3];
  logic [SQ_W-1:0] sqe3_q;
  pre_t            pre3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= SQ_W'(a2_q[i]) * SQ_W'(a2_q[i]);
      end
      sqe3_q       <= SQ_W'(aey2_q) * SQ_W'(aey2_q);
      pre3_q.a[0]  <= a2_q[0];
      pre3_q.a[1]  <= a2_q[1];
      pre3_q.a[2]  <= a2_q[2];
      pre3_q.aey   <= aey2_q;
      pre3_q.ea[0] <= EA_W'(ecc_q) * EA_W'(a2_q[0]);
      pre3_q.ea[1] <= EA_W'(ecc_q) * EA_W'(a2_q[2]);
      pre3_q.neg   <= neg2_q;
      pre3_q.pos_x <= pos2_q[0];
      pre3_q.pos_z <= pos2_q[2];
      pre3_q.eypos <= eypos2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sphere sum; e*dx^2 and e*dz^2 as two half products each
  // --------------------------------------------------------------------------
  logic [S2_W-1:0] s2_4_q;
  logic [PP_W-1:0] pl4_q [2];
  logic [PP_W-1:0] ph4_q [2];
  logic [SQ_W-1:0] sqe4_q;
  pre_t            pre4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_4_q   <= S2_W'(sq3_q[0]) + S2_W'(sq3_q[1]) + S2_W'(sq3_q[2]);
      pl4_q[0] <= PP_W'(ecc_q) * PP_W'(sq3_q[0][HLF-1:0]);
      ph4_q[0] <= PP_W'(ecc_q) * PP_W'(sq3_q[0][SQ_W-1:HLF]);
      pl4_q[1] <= PP_W'(ecc_q) * PP_W'(sq3_q[2][HLF-1:0]);
      ph4_q[1] <= PP_W'(ecc_q) * PP_W'(sq3_q[2][SQ_W-1:HLF]);
      sqe4_q   <= sqe3_q;
      pre4_q   <= pre3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: ellipsoid sum, each weighted term truncated by the fraction
  // --------------------------------------------------------------------------
  logic [EF_W-1:0] ef_d [2];
  logic [E2_W-1:0] e2_d;
  logic [E2_W-1:0] e2_5_q;
  logic [S2_W-1:0] s2_5_q;
  pre_t            pre5_q;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ef_d[j] = (EF_W'(ph4_q[j]) << HLF) + EF_W'(pl4_q[j]);
    end
    e2_d = E2_W'(ET_W'(ef_d[0] >> F)) + E2_W'(ET_W'(ef_d[1] >> F)) + E2_W'(sqe4_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_5_q <= e2_d;
      s2_5_q <= s2_4_q;
      pre5_q <= pre4_q;
    end
  end

  // --------------------------------------------------------------------------
  // both lengths through one square root pipeline
  // --------------------------------------------------------------------------
  logic [1:0][SQI_W-1:0] rad;
  logic [1:0][LEN_W-1:0] root;
  pre_t                  pre_s;

  assign rad[0] = SQI_W'(s2_5_q);
  assign rad[1] = SQI_W'(e2_5_q);

  smef_sqrt #(
    .IN_W  (SQI_W),
    .LANES (2),
    .TAG_W ($bits(pre_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .rad_i   (rad),
    .tag_i   (pre5_q),
    .valid_o (sqrt_vld),
    .root_o  (root),
    .tag_o   (pre_s)
  );

  // --------------------------------------------------------------------------
  // stage 6: pick the branch (a tie goes to the ellipsoid), build numerators
  // --------------------------------------------------------------------------
  logic signed [V_W-1:0] vs_d, ve_d;
  logic                  br_d;
  logic [GN_W-1:0]       num_d [3];
  logic [2:0]            gneg_d;

  always_comb begin
    vs_d = $signed(V_W'(root[0])) - $signed(V_W'(rs_q));
    ve_d = $signed(V_W'(re_q)) - $signed(V_W'(root[1]));
    br_d = !(vs_d > ve_d);
    if (!br_d) begin
      for (int i = 0; i < 3; i++) begin
        num_d[i] = GN_W'(pre_s.a[i]) << F;
      end
      gneg_d = pre_s.neg;
    end else begin
      num_d[0] = GN_W'(pre_s.ea[0]);
      num_d[1] = GN_W'(pre_s.aey) << F;
      num_d[2] = GN_W'(pre_s.ea[1]);
      gneg_d   = {pre_s.pos_z, pre_s.eypos, pre_s.pos_x};
    end
  end

  logic                  br6_q;
  logic [LEN_W-1:0]      len6_q;
  logic signed [V_W-1:0] val6_q;
  logic [2:0][GN_W-1:0]  num6_q;
  logic [2:0]            gneg6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      br6_q     <= br_d;
      len6_q    <= br_d ? root[1] : root[0];
      val6_q    <= br_d ? ve_d : vs_d;
      num6_q[0] <= num_d[0];
      num6_q[1] <= num_d[1];
      num6_q[2] <= num_d[2];
      gneg6_q   <= gneg_d;
    end
  end

  // field value saturates here and rides with the gradient division
  mid_t             mid_d;
  logic [V_W-1:0]   val_mag;

  always_comb begin
    val_mag     = val6_q[V_W-1] ? V_W'(-val6_q) : V_W'(val6_q);
    mid_d.value = sat_fn(val6_q[V_W-1] ^ inside_q, SAT_W'(val_mag));
    mid_d.br    = br6_q;
    mid_d.degen = (len6_q == '0);
    mid_d.gneg  = gneg6_q;
  end

  logic [2:0][G_Q_W-1:0] gq;
  logic [2:0]            govf;
  mid_t                  mid_g;

  smef_div #(
    .NUM_W (GN_W),
    .DEN_W (LEN_W),
    .Q_W   (G_Q_W),
    .LANES (3),
    .TAG_W ($bits(mid_t))
  ) u_div_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (len6_q),
    .tag_i   (mid_d),
    .valid_o (divg_vld),
    .quot_o  (gq),
    .ovf_o   (govf),
    .tag_o   (mid_g)
  );

  // --------------------------------------------------------------------------
  // stage 8: cap the internal gradient, saturate the gradient outputs
  // --------------------------------------------------------------------------
  logic [G_Q_W-1:0] g_d [3];
  logic [G_Q_W-1:0] g8_q [3];
  grd_t             c8_q;
  logic [2:0][W-1:0] grad_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_d[i]    = (govf[i] || (gq[i] > G_CAP)) ? G_CAP : gq[i];
      grad_d[i] = sat_fn(mid_g.gneg[i] ^ inside_q, SAT_W'(g_d[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g8_q       <= g_d;
      c8_q.value <= mid_g.value;
      c8_q.grad  <= grad_d;
      c8_q.br    <= mid_g.br;
      c8_q.degen <= mid_g.degen;
      c8_q.gneg  <= mid_g.gneg;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: partial products of g_i * g_j, 32-bit low and 31-bit high halves
  // --------------------------------------------------------------------------
  logic [63:0] pp9_q [6][4];
  grd_t        c9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < 6; p++) begin
        pp9_q[p][0] <= 64'(g8_q[PI[p]][G_LO_W-1:0]) * 64'(g8_q[PJ[p]][G_LO_W-1:0]);
        pp9_q[p][1] <= 64'(g8_q[PI[p]][G_LO_W-1:0]) * 64'(g8_q[PJ[p]][G_Q_W-1:G_LO_W]);
        pp9_q[p][2] <= 64'(g8_q[PI[p]][G_Q_W-1:G_LO_W]) * 64'(g8_q[PJ[p]][G_LO_W-1:0]);
        pp9_q[p][3] <= 64'(g8_q[PI[p]][G_Q_W-1:G_LO_W]) * 64'(g8_q[PJ[p]][G_Q_W-1:G_LO_W]);
      end
      c9_q <= c8_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: assemble the full products
  // --------------------------------------------------------------------------
  logic [GG_W-1:0] prod10_q [6];
  grd_t            c10_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < 6; p++) begin
        prod10_q[p] <= GG_W'(pp9_q[p][0])
                     + ((GG_W'(pp9_q[p][1]) + GG_W'(pp9_q[p][2])) << G_LO_W)
                     + (GG_W'(pp9_q[p][3]) << (2 * G_LO_W));
      end
      c10_q <= c9_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 11: hessian numerators and signs
  // diagonal: w*2^F - g^2, w = e on ellipsoid x and z, else 1.0
  // --------------------------------------------------------------------------
  logic [5:0][GG_W-1:0] hmag_d;
  logic [5:0]           hsgn_d;
  logic [5:0][GG_W-1:0] hmag11_q;
  res_t                 r11_q;

  always_comb begin
    logic [WT_W-1:0] wt;
    logic [GG_W-1:0] lhs;
    for (int i = 0; i < 3; i++) begin
      wt  = (c10_q.br && (i != 1)) ? WT_W'(ecc_q) : (WT_W'(1) << F);
      lhs = GG_W'(wt) << F;
      if (lhs >= prod10_q[i]) begin
        hmag_d[i] = lhs - prod10_q[i];
        hsgn_d[i] = c10_q.br ^ inside_q;
      end else begin
        hmag_d[i] = prod10_q[i] - lhs;
        hsgn_d[i] = !c10_q.br ^ inside_q;
      end
    end
    for (int p = 3; p < 6; p++) begin
      hmag_d[p] = prod10_q[p];
      hsgn_d[p] = c10_q.gneg[PI[p]] ^ c10_q.gneg[PJ[p]] ^ !c10_q.br ^ inside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hmag11_q    <= hmag_d;
      r11_q.value <= c10_q.value;
      r11_q.grad  <= c10_q.grad;
      r11_q.br    <= c10_q.br;
      r11_q.degen <= c10_q.degen;
      r11_q.hsgn  <= hsgn_d;
    end
  end

  // the length still sits in the gradient divider's copy, so carry it here
  logic [LEN_W-1:0] len8_q, len9_q, len10_q, len11_q;
  logic [LEN_W-1:0] len_g;

  logic [5:0][W-1:0] hq;
  logic [5:0]        hovf;
  res_t              res_h;

  // hessian terms divided by the same length, taken from the delay line
  smef_div #(
    .NUM_W (GG_W),
    .DEN_W (LEN_W),
    .Q_W   (W),
    .LANES (6),
    .TAG_W ($bits(res_t))
  ) u_div_hess (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v11_q),
    .num_i   (hmag11_q),
    .den_i   (len11_q),
    .tag_i   (r11_q),
    .valid_o (divh_vld),
    .quot_o  (hq),
    .ovf_o   (hovf),
    .tag_o   (res_h)
  );

  // length delay line alongside the gradient divider
  logic [LEN_W-1:0] len_dl_q [G_Q_W+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_dl_q[0] <= len6_q;
      for (int k = 0; k < G_Q_W; k++) begin
        len_dl_q[k+1] <= len_dl_q[k];
      end
      len8_q  <= len_g;
      len9_q  <= len8_q;
      len10_q <= len9_q;
      len11_q <= len10_q;
    end
  end

  assign len_g = len_dl_q[G_Q_W];

  // --------------------------------------------------------------------------
  // output register: saturate the hessian, zero gradient and hessian on a zero length
  // --------------------------------------------------------------------------
  logic [OUT_TD_W-1:0] tdata_d, tdata_q;
  logic [1:0]          tuser_d, tuser_q;

  always_comb begin
    tdata_d          = '0;
    tdata_d[W-1:0]   = res_h.value;
    for (int i = 0; i < 3; i++) begin
      tdata_d[(1+i)*W +: W] = res_h.degen ? '0 : res_h.grad[i];
    end
    for (int p = 0; p < 6; p++) begin
      tdata_d[(4+p)*W +: W] = res_h.degen ? '0 :
                              sat_fn(res_h.hsgn[p], SAT_W'({hovf[p], hq[p]}));
    end
    tuser_d = {res_h.degen, res_h.br};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tvalid = out_vld_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[OUT_TD_W-1:W] == '0))
    else $error("degenerate beat with nonzero gradient or hessian");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output is free");

  a_inside_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_INSIDE_MODE)) |=> (inside_q == $past(cfg_data_i[0])))
    else $error("inside_mode write lost");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the sphere minus ellipsoid field evaluator
// streams query points through the block under random gaps and stalls on both
// sides and checks every output beat against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import smef_pkg::*;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int LATENCY   = 151;
  localparam int IDLE_MAX  = 20000;  // cycles with no beat on either side
  localparam int HOLD_LEN  = 500;    // long receiver hold-off

  logic clk_i;
  logic rst_ni;

  logic [95:0]  s_axis_tdata;   // point_x, point_y, point_z
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // field_value, grad_x, grad_y, grad_z, hess_xx, hess_yy, hess_zz,
  // hess_xy, hess_xz, hess_yz
  logic [319:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;   // ellipsoid_branch, degenerate
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DW-1:0] cfg_data_i;

  sphere_minus_ellipsoid_field #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // expected output of one point
  typedef struct {
    logic [DW-1:0] val [10];
    logic          branch;
    logic          degen;
  } field_out_t;

  // mirror of the register file
  logic          inside_q;
  logic [DW-1:0] cx_q, cy_q, cz_q, shift_q;
  logic [DW-2:0] rs_q, re_q, ecc_q;

  field_out_t field_q[$];
  int  errors;
  bit  no_idle;       // stretch with no gaps on either side
  bit  hold_req;      // ask the receiver for a long hold-off
  int  idle_cnt;

  string field_names [10] = '{"field_value", "grad_x", "grad_y", "grad_z", "hess_xx",
                              "hess_yy", "hess_zz", "hess_xy", "hess_xz", "hess_yz"};

  // ---------------------------------------------------------------------------
  // fixed-point field predictor
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  // clamp a sign and magnitude to signed DW bits
  function automatic logic [DW-1:0] clamp_q(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    logic [127:0] v;
    lim = neg ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
    v   = (mag > lim) ? lim : mag;
    if (neg) v = -v;
    return v[DW-1:0];
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic field_out_t eval_field(logic [DW-1:0] px, logic [DW-1:0] py,
                                            logic [DW-1:0] pz);
    field_out_t   r;
    longint       d [3];
    longint       ey, vs, ve, fv;
    logic [63:0]  a [3];
    logic [63:0]  aey, e, ls, le, len, w;
    logic [127:0] s2, e2, num, lhs, sq, mag;
    logic [127:0] g [3];
    bit           gneg [3];
    bit           br, nneg, sgn;
    int           pi_, pj_;
    d[0] = longint'($signed(px)) - longint'($signed(cx_q));
    d[1] = longint'($signed(py)) - longint'($signed(cy_q));
    d[2] = longint'($signed(pz)) - longint'($signed(cz_q));
    ey   = d[1] - longint'($signed(shift_q));
    for (int i = 0; i < 3; i++) a[i] = mag64(d[i]);
    aey = mag64(ey);
    e   = 64'(ecc_q);

    s2 = {64'd0, a[0]} * a[0] + {64'd0, a[1]} * a[1] + {64'd0, a[2]} * a[2];
    ls = isqrt128(s2);
    e2 = (({64'd0, a[0]} * a[0] * e) >> FB) + {64'd0, aey} * aey
       + (({64'd0, a[2]} * a[2] * e) >> FB);
    le = isqrt128(e2);

    vs = longint'(ls) - longint'(64'(rs_q));
    ve = longint'(64'(re_q)) - longint'(le);
    br = !(vs > ve);  // tie goes to the ellipsoid
    fv = br ? ve : vs;
    r.val[0] = clamp_q((fv < 0) != inside_q, {64'd0, mag64(fv)});
    r.branch = br;
    len      = br ? le : ls;

    if (len == 0) begin
      // degenerate length: derivatives forced to zero
      for (int k = 1; k < 10; k++) r.val[k] = '0;
      r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;

    for (int i = 0; i < 3; i++) begin
      if (!br) begin
        num = {64'd0, a[i]} << FB;
        gneg[i] = d[i] < 0;
      end else if (i == 1) begin
        num = {64'd0, aey} << FB;
        gneg[i] = ey > 0;
      end else begin
        num = {64'd0, e} * a[i];
        gneg[i] = d[i] > 0;
      end
      g[i] = num / {64'd0, len};
      if (g[i] > (128'd1 << 62)) g[i] = 128'd1 << 62;
      r.val[1+i] = clamp_q(gneg[i] != inside_q, g[i]);
    end

    for (int i = 0; i < 3; i++) begin
      w   = (br && i != 1) ? e : (64'd1 << FB);
      lhs = {64'd0, w} << FB;
      sq  = g[i] * g[i];
      if (lhs >= sq) begin
        mag = lhs - sq;
        nneg = 1'b0;
      end else begin
        mag = sq - lhs;
        nneg = 1'b1;
      end
      r.val[4+i] = clamp_q((nneg != br) != inside_q, mag / {64'd0, len});
    end

    // off-diagonal pairs xy, xz, yz
    for (int k = 0; k < 3; k++) begin
      pi_ = (k == 2) ? 1 : 0;
      pj_ = (k == 0) ? 1 : 2;
      mag = g[pi_] * g[pj_];
      sgn = ((gneg[pi_] != gneg[pj_]) != !br) != inside_q;
      r.val[7+k] = clamp_q(sgn, mag / {64'd0, len});
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // config port
  // ---------------------------------------------------------------------------
  // leaves the write enable high; cfg_close drops it
  task automatic write_reg(smef_reg_e idx, logic [DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_INSIDE_MODE:      inside_q = data[0];
      REG_CENTER_X:         cx_q     = data;
      REG_CENTER_Y:         cy_q     = data;
      REG_CENTER_Z:         cz_q     = data;
      REG_SPHERE_RADIUS:    rs_q     = data[DW-2:0];
      REG_ELLIPSOID_SHIFT:  shift_q  = data;
      REG_ELLIPSOID_RADIUS: re_q     = data[DW-2:0];
      REG_ECCENTRICITY:     ecc_q    = data[DW-2:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(bit inv, logic [DW-1:0] cx, logic [DW-1:0] cy,
                            logic [DW-1:0] cz, logic [DW-1:0] rs,
                            logic [DW-1:0] sh, logic [DW-1:0] re,
                            logic [DW-1:0] ecc);
    write_reg(REG_INSIDE_MODE, {31'd0, inv});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_SPHERE_RADIUS, rs);
    write_reg(REG_ELLIPSOID_SHIFT, sh);
    write_reg(REG_ELLIPSOID_RADIUS, re);
    write_reg(REG_ECCENTRICITY, ecc);
    cfg_close();
  endtask

  // moderate values half the time, otherwise an extreme or full range
  function automatic logic [DW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4:    return $urandom;
      default: return 32'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
    endcase
  endfunction

  task automatic random_config();
    set_config($urandom_range(0, 1), pick_value(), pick_value(), pick_value(),
               ($urandom_range(0, 3) == 0) ? pick_value() : $urandom_range(0, 8 << FB),
               pick_value(),
               ($urandom_range(0, 3) == 0) ? pick_value() : $urandom_range(0, 8 << FB),
               ($urandom_range(0, 3) == 0) ? pick_value() : $urandom_range(0, 4 << FB));
  endtask

  // ---------------------------------------------------------------------------
  // point sender
  // ---------------------------------------------------------------------------
  // keeps tvalid high after the beat; the gap task lowers it
  task automatic send_point(logic [DW-1:0] px, logic [DW-1:0] py, logic [DW-1:0] pz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    field_q.push_back(eval_field(px, py, pz));
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 19))
        0:             n = $urandom_range(10, 40);
        1, 2, 3, 4, 5: n = $urandom_range(1, 3);
        default:       n = 0;
      endcase
    end
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_random_points(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_point(pick_value(), pick_value(), pick_value());
      sender_gap();
    end
    no_idle = 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus a requested long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle) begin
          case ($urandom_range(0, 29))
            0:             stall = $urandom_range(15, 60);
            1, 2, 3, 4, 5: stall = $urandom_range(1, 3);
            default:       stall = 0;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    field_out_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (field_q.size() == 0) begin
        $error("output beat with no point pending");
        errors++;
      end else begin
        exp_r = field_q.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (m_axis_tdata[k*DW +: DW] !== exp_r.val[k]) begin
            $error("%s expected %h actual %h", field_names[k], exp_r.val[k],
                   m_axis_tdata[k*DW +: DW]);
            errors++;
          end
        end
        if (m_axis_tuser[0] !== exp_r.branch) begin
          $error("ellipsoid_branch expected %b actual %b", exp_r.branch, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== exp_r.degen) begin
          $error("degenerate expected %b actual %b", exp_r.degen, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset values and other settings, field extremes, ties, both branches, zero lengths
  task automatic test_directed();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_point(32'h0002_0000, 32'h0, 32'h0);       // sphere side
    send_point(32'h0, 32'h0001_8000, 32'h0);       // close to the ellipsoid
    // ellipsoid length zero: point on the ellipsoid center
    send_point(32'h0, 32'h0001_0000, 32'h0);
    sender_gap();
    drain();
    // sphere length zero: zero radii make the sphere win at its center
    set_config(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0, 32'h0001_0000, 32'h0);
    drain();
    // inside mode with a most negative field value
    set_config(1'b1, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
               32'h7fff_ffff);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0, 32'h7fff_ffff, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
    drain();
    // extreme centers, zero eccentricity
    set_config(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_backpressure();
    random_config();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    for (int i = 0; i < 250; i++) send_point(pick_value(), pick_value(), pick_value());
    no_idle = 1'b0;
    drain();
  endtask

  // random points over a series of random settings
  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      random_config();
      send_random_points(105);
      drain();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_INSIDE_MODE;
    cfg_data_i    = '0;
    errors        = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    idle_cnt      = 0;
    inside_q      = 1'b0;
    cx_q          = '0;
    cy_q          = '0;
    cz_q          = '0;
    rs_q          = 31'd65536;
    shift_q       = 32'd65536;
    re_q          = 31'd65536;
    ecc_q         = 31'd65536;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
